FILE: design/tfrt_pkg.sv
// tfrt_pkg: field widths, list depth, command codes and list selects for the top-five read tracker
// no dependencies

package tfrt_pkg;

    localparam int LIST_DEPTH = 5;

    localparam int LEN_W     = 31;
    localparam int QUAL_W    = 16;
    localparam int IDX_IN_W  = 3;
    localparam int RANK_OUT_W = 3;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_READ   = 1'b1
    } cmd_t;

    typedef enum logic {
        SEL_QUALITY = 1'b0,
        SEL_LENGTH  = 1'b1
    } list_sel_t;

endpackage

FILE: design/top_five_read_tracker_unit.sv
// top_five_read_tracker_unit: two descending top-k read lists, ranked by quality and by length
// depends on tfrt_pkg
//
// channel   | dir | tdata (low bit up)                                    | tuser
// s_axis    | in  | read_length[30:0] mean_quality[46:31]                 | cmd[0] list_select[1]
//                     entry_index[49:47]
// m_axis    | out | quality_rank[2:0] length_rank[5:3] entry_length[36:6] | -
//                     entry_quality[52:37]
//
// one word per cycle sustained while m_axis is ready; each input word passes in order through
// the input register, then compare and shift-insert into the result register
// lists update on an insert word as it moves from the input register to the result register
// reset clears both lists to zero and empties both registers
// a stall on m_axis holds the result word and backs up into s_axis_tready

module top_five_read_tracker_unit
    import tfrt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // read_length, mean_quality, entry_index
    input  logic [S_TUSER_W-1:0] s_axis_tuser,  // cmd, list_select
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // quality_rank, length_rank, entry_length,
                                                // entry_quality
);

    localparam int RANK_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    // input register
    logic                in_valid_reg;
    cmd_t                in_cmd_reg;
    list_sel_t           in_sel_reg;
    logic [LEN_W-1:0]    in_length_reg;
    logic [QUAL_W-1:0]   in_quality_reg;
    logic [IDX_IN_W-1:0] in_index_reg;

    // result register
    logic                  out_valid_reg;
    logic [RANK_OUT_W-1:0] out_qrank_reg;
    logic [RANK_OUT_W-1:0] out_lrank_reg;
    logic [LEN_W-1:0]      out_length_reg;
    logic [QUAL_W-1:0]     out_quality_reg;

    // lists
    logic [QUAL_W-1:0] ql_quality_reg [LIST_DEPTH];
    logic [LEN_W-1:0]  ql_length_reg  [LIST_DEPTH];
    logic [LEN_W-1:0]  ll_length_reg  [LIST_DEPTH];
    logic [QUAL_W-1:0] ll_quality_reg [LIST_DEPTH];

    logic [QUAL_W-1:0] ql_quality_next [LIST_DEPTH];
    logic [LEN_W-1:0]  ql_length_next  [LIST_DEPTH];
    logic [LEN_W-1:0]  ll_length_next  [LIST_DEPTH];
    logic [QUAL_W-1:0] ll_quality_next [LIST_DEPTH];

    logic [LIST_DEPTH-1:0] q_gt;
    logic [LIST_DEPTH-1:0] l_gt;
    logic [RANK_W-1:0]     q_rank;
    logic [RANK_W-1:0]     l_rank;

    logic                  advance;
    logic                  index_ok;
    logic [IDX_W-1:0]      rd_index;
    logic [RANK_OUT_W-1:0] qrank_next;
    logic [RANK_OUT_W-1:0] lrank_next;
    logic [LEN_W-1:0]      elen_next;
    logic [QUAL_W-1:0]     equal_next;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_quality_reg, out_length_reg,
                            out_lrank_reg, out_qrank_reg};

    // compare and shift-insert, both lists
    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            q_gt[i] = ql_quality_reg[i] < in_quality_reg;
            l_gt[i] = ll_length_reg[i] < in_length_reg;
        end

        ql_quality_next[0] = q_gt[0] ? in_quality_reg : ql_quality_reg[0];
        ql_length_next[0]  = q_gt[0] ? in_length_reg  : ql_length_reg[0];
        ll_length_next[0]  = l_gt[0] ? in_length_reg  : ll_length_reg[0];
        ll_quality_next[0] = l_gt[0] ? in_quality_reg : ll_quality_reg[0];
        for (int i = 1; i < LIST_DEPTH; i++)
        begin
            if (!q_gt[i])
            begin
                ql_quality_next[i] = ql_quality_reg[i];
                ql_length_next[i]  = ql_length_reg[i];
            end
            else if (q_gt[i-1])
            begin
                ql_quality_next[i] = ql_quality_reg[i-1];
                ql_length_next[i]  = ql_length_reg[i-1];
            end
            else
            begin
                ql_quality_next[i] = in_quality_reg;
                ql_length_next[i]  = in_length_reg;
            end

            if (!l_gt[i])
            begin
                ll_length_next[i]  = ll_length_reg[i];
                ll_quality_next[i] = ll_quality_reg[i];
            end
            else if (l_gt[i-1])
            begin
                ll_length_next[i]  = ll_length_reg[i-1];
                ll_quality_next[i] = ll_quality_reg[i-1];
            end
            else
            begin
                ll_length_next[i]  = in_length_reg;
                ll_quality_next[i] = in_quality_reg;
            end
        end

        // lists stay descending, so the slot is the count of entries not below the key
        q_rank = '0;
        l_rank = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            q_rank = q_rank + RANK_W'(!q_gt[i]);
            l_rank = l_rank + RANK_W'(!l_gt[i]);
        end
    end

    // result word
    always_comb
    begin
        index_ok   = 32'(in_index_reg) < LIST_DEPTH;
        rd_index   = IDX_W'(in_index_reg);
        qrank_next = RANK_OUT_W'(LIST_DEPTH);
        lrank_next = RANK_OUT_W'(LIST_DEPTH);
        elen_next  = '0;
        equal_next = '0;
        unique case (in_cmd_reg)
            CMD_INSERT:
            begin
                qrank_next = RANK_OUT_W'(q_rank);
                lrank_next = RANK_OUT_W'(l_rank);
            end
            CMD_READ:
            begin
                if (index_ok)
                begin
                    unique case (in_sel_reg)
                        SEL_QUALITY:
                        begin
                            elen_next  = ql_length_reg[rd_index];
                            equal_next = ql_quality_reg[rd_index];
                        end
                        SEL_LENGTH:
                        begin
                            elen_next  = ll_length_reg[rd_index];
                            equal_next = ll_quality_reg[rd_index];
                        end
                        default:
                        begin
                            elen_next  = '0;
                            equal_next = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                qrank_next = RANK_OUT_W'(LIST_DEPTH);
                lrank_next = RANK_OUT_W'(LIST_DEPTH);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_cmd_reg     <= cmd_t'(s_axis_tuser[0]);
            in_sel_reg     <= list_sel_t'(s_axis_tuser[1]);
            in_length_reg  <= s_axis_tdata[30:0];
            in_quality_reg <= s_axis_tdata[46:31];
            in_index_reg   <= s_axis_tdata[49:47];
        end
        if (advance && in_valid_reg)
        begin
            out_qrank_reg   <= qrank_next;
            out_lrank_reg   <= lrank_next;
            out_length_reg  <= elen_next;
            out_quality_reg <= equal_next;
        end
    end

    // list state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIST_DEPTH; i++)
            begin
                ql_quality_reg[i] <= '0;
                ql_length_reg[i]  <= '0;
                ll_length_reg[i]  <= '0;
                ll_quality_reg[i] <= '0;
            end
        end
        else if (advance && in_valid_reg && (in_cmd_reg == CMD_INSERT))
        begin
            for (int i = 0; i < LIST_DEPTH; i++)
            begin
                ql_quality_reg[i] <= ql_quality_next[i];
                ql_length_reg[i]  <= ql_length_next[i];
                ll_length_reg[i]  <= ll_length_next[i];
                ll_quality_reg[i] <= ll_quality_next[i];
            end
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
// tb_top: self-checking bench for top_five_read_tracker_unit, inserts and readbacks on the stream
// ports are checked against a cycle-free model of both top-five lists; depends on tfrt_pkg
// and on design/top_five_read_tracker_unit.sv
`timescale 1ns / 100ps

module tb_top;
    import tfrt_pkg::*;

    localparam int TRACK_DEPTH = LIST_DEPTH;
    localparam int N_RANDOM    = 1200;
    localparam int IDLE_PCT    = 37;
    localparam int CYCLE_LIMIT = 200000;
    localparam int QUIET_FROM  = 400;
    localparam int QUIET_TO    = 1000;
    localparam longint LEN_MAX  = 64'h7FFF_FFFF;
    localparam longint QUAL_MAX = 64'hFFFF;

    typedef struct {
        cmd_t                cmd;
        logic [LEN_W-1:0]    len;
        logic [QUAL_W-1:0]   qual;
        list_sel_t           sel;
        logic [IDX_IN_W-1:0] idx;
    } tracker_cmd_t;

    typedef struct {
        logic [RANK_OUT_W-1:0] qrank;
        logic [RANK_OUT_W-1:0] lrank;
        logic [LEN_W-1:0]      len;
        logic [QUAL_W-1:0]     qual;
    } tracker_out_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // read_length, mean_quality, entry_index
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;  // cmd, list_select
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;       // quality_rank, length_rank, entry_length,
                                              // entry_quality

    tracker_cmd_t read_cmd_q[$];
    tracker_out_t tracker_out_q[$];
    tracker_cmd_t drv_cmd;

    logic [QUAL_W-1:0] qlist_qual [TRACK_DEPTH];
    logic [LEN_W-1:0]  qlist_len  [TRACK_DEPTH];
    logic [LEN_W-1:0]  llist_len  [TRACK_DEPTH];
    logic [QUAL_W-1:0] llist_qual [TRACK_DEPTH];

    int cyc = 0;
    int errors = 0;
    int n_inserts = 0;
    int n_readbacks = 0;
    int n_qual_entered = 0;
    int n_len_entered = 0;
    int n_checked = 0;
    bit quiet;

    top_five_read_tracker_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

    function automatic tracker_out_t track_read_item(tracker_cmd_t c);
        tracker_out_t r;
        int qslot;
        int lslot;
        r.qrank = RANK_OUT_W'(TRACK_DEPTH);
        r.lrank = RANK_OUT_W'(TRACK_DEPTH);
        r.len   = '0;
        r.qual  = '0;
        if (c.cmd == CMD_INSERT)
        begin
            n_inserts++;
            qslot = TRACK_DEPTH;
            lslot = TRACK_DEPTH;
            for (int i = 0; i < TRACK_DEPTH; i++)
            begin
                if (qslot == TRACK_DEPTH && qlist_qual[i] < c.qual)
                    qslot = i;
                if (lslot == TRACK_DEPTH && llist_len[i] < c.len)
                    lslot = i;
            end
            if (qslot < TRACK_DEPTH)
            begin
                for (int j = TRACK_DEPTH - 1; j > qslot; j--)
                begin
                    qlist_qual[j] = qlist_qual[j-1];
                    qlist_len[j]  = qlist_len[j-1];
                end
                qlist_qual[qslot] = c.qual;
                qlist_len[qslot]  = c.len;
                n_qual_entered++;
            end
            if (lslot < TRACK_DEPTH)
            begin
                for (int j = TRACK_DEPTH - 1; j > lslot; j--)
                begin
                    llist_len[j]  = llist_len[j-1];
                    llist_qual[j] = llist_qual[j-1];
                end
                llist_len[lslot]  = c.len;
                llist_qual[lslot] = c.qual;
                n_len_entered++;
            end
            r.qrank = qslot[RANK_OUT_W-1:0];
            r.lrank = lslot[RANK_OUT_W-1:0];
        end
        else
        begin
            n_readbacks++;
            if (c.idx < TRACK_DEPTH)
            begin
                if (c.sel == SEL_QUALITY)
                begin
                    r.len  = qlist_len[c.idx];
                    r.qual = qlist_qual[c.idx];
                end
                else
                begin
                    r.len  = llist_len[c.idx];
                    r.qual = llist_qual[c.idx];
                end
            end
        end
        return r;
    endfunction

    task automatic add_insert(longint len, longint qual);
        tracker_cmd_t c;
        c.cmd  = CMD_INSERT;
        c.len  = len[LEN_W-1:0];
        c.qual = qual[QUAL_W-1:0];
        c.sel  = list_sel_t'($urandom_range(0, 1));
        c.idx  = IDX_IN_W'($urandom_range(0, 7));
        read_cmd_q.push_back(c);
    endtask

    task automatic add_read(list_sel_t sel, int idx);
        tracker_cmd_t c;
        c.cmd  = CMD_READ;
        c.len  = LEN_W'($urandom);
        c.qual = QUAL_W'($urandom);
        c.sel  = sel;
        c.idx  = idx[IDX_IN_W-1:0];
        read_cmd_q.push_back(c);
    endtask

    // keys follow a rising base so that late reads still compete for the lists
    function automatic longint pick_key(longint base, longint maxv);
        longint k;
        int mode;
        int w;
        mode = $urandom_range(0, 99);
        w = $urandom_range(0, 8);
        k = base + ($urandom & ((1 << w) - 1));
        if (mode < 8)
            k = 0;
        else if (mode < 22)
            k = base / 2 + ($urandom & 255);
        if (k > maxv)
            k = maxv;
        return k;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                tracker_out_q.push_back(track_read_item(drv_cmd));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (read_cmd_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    drv_cmd = read_cmd_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(S_TDATA_W-50){1'b0}}, drv_cmd.idx, drv_cmd.qual,
                                      drv_cmd.len};
                    s_axis_tuser  <= {drv_cmd.sel, drv_cmd.cmd};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        tracker_out_t e;
        tracker_out_t a;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                a.qrank = m_axis_tdata[2:0];
                a.lrank = m_axis_tdata[5:3];
                a.len   = m_axis_tdata[36:6];
                a.qual  = m_axis_tdata[52:37];
                if (tracker_out_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR cycle %0d: result word with nothing expected: %h",
                                 cyc, m_axis_tdata);
                end
                else
                begin
                    e = tracker_out_q.pop_front();
                    n_checked++;
                    if (a.qrank !== e.qrank || a.lrank !== e.lrank ||
                        a.len !== e.len || a.qual !== e.qual)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $write("ERROR cycle %0d word %0d: exp q%0d l%0d len %h qual %h, ",
                                   cyc, n_checked, e.qrank, e.lrank, e.len, e.qual);
                            $display("got q%0d l%0d len %h qual %h",
                                     a.qrank, a.lrank, a.len, a.qual);
                        end
                    end
                end
            end
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT)
        begin
            $display("top_five_read_tracker_unit test failed");
            $finish;
        end
    end

    initial
    begin
        longint lbase;
        longint qbase;
        for (int i = 0; i < TRACK_DEPTH; i++)
        begin
            qlist_qual[i] = '0;
            qlist_len[i]  = '0;
            llist_len[i]  = '0;
            llist_qual[i] = '0;
        end

        // empty lists, zero keys, extremes, ties and the list tail dropping out
        add_read(SEL_QUALITY, 0);
        add_insert(0, 0);
        add_insert(LEN_MAX, 0);
        add_insert(0, QUAL_MAX);
        add_insert(100, 16'h1E00);
        add_insert(100, 16'h1E00);
        add_insert(1, 1);
        add_insert(50, 16'h0100);
        add_insert(LEN_MAX, QUAL_MAX);
        add_insert(2, 2);
        for (int i = 0; i < 8; i++)
            add_read(SEL_QUALITY, i);
        for (int i = 0; i < 8; i++)
            add_read(SEL_LENGTH, i);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            lbase = longint'(i / 8) * 8 * 1789569;
            qbase = longint'(i / 8) * 8 * 54;
            if ($urandom_range(0, 99) < 30)
                add_read(list_sel_t'($urandom_range(0, 1)), $urandom_range(0, 7));
            else
                add_insert(pick_key(lbase, LEN_MAX), pick_key(qbase, QUAL_MAX));
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (read_cmd_q.size() != 0 || s_axis_tvalid || tracker_out_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d inserts (%0d into quality list, %0d into length list)",
                 n_inserts, n_qual_entered, n_len_entered);
        $display("and %0d entry readbacks, %0d result words checked, %0d mismatches",
                 n_readbacks, n_checked, errors);
        if (errors == 0)
            $display("top_five_read_tracker_unit test passed");
        else
            $display("top_five_read_tracker_unit test failed");
        $finish;
    end

endmodule
